// ----- sv/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/lcdmt_pkg.sv -----
package lcdmt_pkg;

  localparam int KIND_W  = 2;
  localparam int SEL_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 2;
  localparam int ACC_W   = 16;
  localparam int MODE_W  = 2;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  // display register selectors
  localparam logic [SEL_W-1:0] REG_CONTROL = 4'd0;
  localparam logic [SEL_W-1:0] REG_STATUS  = 4'd1;
  localparam logic [SEL_W-1:0] REG_SCROLLY = 4'd2;
  localparam logic [SEL_W-1:0] REG_SCROLLX = 4'd3;
  localparam logic [SEL_W-1:0] REG_LINE    = 4'd4;
  localparam logic [SEL_W-1:0] REG_COMPARE = 4'd5;
  localparam logic [SEL_W-1:0] REG_DMA     = 4'd6;
  localparam logic [SEL_W-1:0] REG_BGPAL   = 4'd7;
  localparam logic [SEL_W-1:0] REG_OBPAL0  = 4'd8;
  localparam logic [SEL_W-1:0] REG_OBPAL1  = 4'd9;
  localparam logic [SEL_W-1:0] REG_WINY    = 4'd10;
  localparam logic [SEL_W-1:0] REG_WINX    = 4'd11;

  // timing register indexes
  localparam logic [CIDX_W-1:0] CFG_HBLANK = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_VBLANK = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_OAM    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_XFER   = 2'd3;

  localparam logic [CFG_W-1:0] HBLANK_RST = 10'd204;
  localparam logic [CFG_W-1:0] VBLANK_RST = 10'd456;
  localparam logic [CFG_W-1:0] OAM_RST    = 10'd80;
  localparam logic [CFG_W-1:0] XFER_RST   = 10'd172;

  // status register layout
  localparam logic [BYTE_W-1:0] ST_WRITABLE = 8'hF8;
  localparam logic [BYTE_W-1:0] ST_READONLY = 8'h07;
  localparam int ST_COINC_BIT = 2;
  localparam int ST_HBL_BIT   = 3;
  localparam int ST_VBL_BIT   = 4;
  localparam int ST_OAM_BIT   = 5;
  localparam int ST_LYC_BIT   = 6;

  // mode codes as seen on the bus
  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  typedef enum logic [3:0] {
    VM_HBLANK = 4'b0001,
    VM_VBLANK = 4'b0010,
    VM_OAM    = 4'b0100,
    VM_XFER   = 4'b1000
  } vmode_t;

  function automatic logic [MODE_W-1:0] vmode_code(input vmode_t vm);
    logic [MODE_W-1:0] code;
    unique case (vm)
      VM_HBLANK: code = MODE_HBLANK;
      VM_VBLANK: code = MODE_VBLANK;
      VM_OAM:    code = MODE_OAM;
      VM_XFER:   code = MODE_XFER;
      default:   code = MODE_OAM;
    endcase
    return code;
  endfunction

endpackage

// ----- sv/lcd_mode_timing_and_registers.sv -----
// channel  | beat fields, low bit first
// ---------+-------------------------------------------------------------
// s_axis   | tuser: kind[1:0]; tdata: reg_select[3:0] write_data[11:4]
//          |        cycles[19:12], zero pad to 24 bits
// m_axis   | tdata: read_data[7:0] vblank_irq[8] lcd_irq[9] dma_start[10]
//          |        dma_page[18:11] mode[20:19], zero pad to 24 bits
// cfg      | cfg_write, cfg_index (0 hblank, 1 vblank line, 2 oam, 3 xfer),
//          | cfg_data (10 bits)
//
// one beat in and one beat out per cycle when both sides flow; a beat
// is resolved against the mode timer and register file while it sits in
// the input register, and lands in the output register
// reset (rst, synchronous) restores the timing registers, the display
// registers and oam search mode and empties both pipeline registers
// a stalled output holds its beat; the input register keeps taking beats as
// long as the output register can drain or is empty
`include "assert_macros.svh"

module lcd_mode_timing_and_registers #(
  parameter int VBLANK_FIRST_LINE = 144,
  parameter int LAST_LINE         = 153
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // reg_select, write_data, cycles, pad
  input  logic [lcdmt_pkg::IN_W-1:0]    s_axis_tdata,
  // kind
  input  logic [lcdmt_pkg::KIND_W-1:0]  s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data, vblank_irq, lcd_irq, dma_start, dma_page, mode, pad
  output logic [lcdmt_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                          cfg_write,
  input  logic [lcdmt_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lcdmt_pkg::CFG_W-1:0]   cfg_data
);

  import lcdmt_pkg::*;

  localparam logic [BYTE_W-1:0] VBL_LINE  = BYTE_W'(VBLANK_FIRST_LINE);
  localparam logic [BYTE_W-1:0] LAST_LINE_B = BYTE_W'(LAST_LINE);

  // timing registers
  logic [CFG_W-1:0] hblank_cycles, vblank_line_cycles, oam_search_cycles, transfer_cycles;

  // mode timer and display register file
  vmode_t           vmode, vmode_next;
  logic [ACC_W-1:0] cycle_accum, cycle_accum_next;
  logic [BYTE_W-1:0] line_counter, line_counter_next;
  logic [BYTE_W-1:0] lcd_control, lcd_control_next;
  logic [4:0]       status_en, status_en_next;   // status bits 7..3
  logic             coinc, coinc_next;           // status bit 2
  logic [BYTE_W-1:0] view_y, view_y_next;
  logic [BYTE_W-1:0] view_x, view_x_next;
  logic [BYTE_W-1:0] line_compare, line_compare_next;
  logic [BYTE_W-1:0] bg_palette, bg_palette_next;
  logic [BYTE_W-1:0] obj_palette0, obj_palette0_next;
  logic [BYTE_W-1:0] obj_palette1, obj_palette1_next;
  logic [BYTE_W-1:0] window_y, window_y_next;
  logic [BYTE_W-1:0] window_x, window_x_next;

  // input register
  logic              in_valid;
  logic [KIND_W-1:0] in_kind;
  logic [SEL_W-1:0]  in_sel;
  logic [BYTE_W-1:0] in_wdata;
  logic [BYTE_W-1:0] in_cyc;

  // result of the beat held in the input register
  logic [BYTE_W-1:0] rd_data;
  logic              vbl_irq, stat_irq, dma_req;
  logic [BYTE_W-1:0] dma_byte;

  // output register
  logic [BYTE_W-1:0] o_read_data, o_dma_page;
  logic              o_vblank_irq, o_lcd_irq, o_dma_start;
  logic [MODE_W-1:0] o_mode;

  logic advance;
  logic [BYTE_W-1:0] status_byte;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign status_byte   = {status_en, coinc, vmode_code(vmode)};

  // timing registers take writes whenever offered
  always_ff @(posedge clk) begin
    if (rst) begin
      hblank_cycles      <= HBLANK_RST;
      vblank_line_cycles <= VBLANK_RST;
      oam_search_cycles  <= OAM_RST;
      transfer_cycles    <= XFER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_HBLANK: hblank_cycles      <= cfg_data;
        CFG_VBLANK: vblank_line_cycles <= cfg_data;
        CFG_OAM:    oam_search_cycles  <= cfg_data;
        CFG_XFER:   transfer_cycles    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind  <= s_axis_tuser;
      in_sel   <= s_axis_tdata[3:0];
      in_wdata <= s_axis_tdata[11:4];
      in_cyc   <= s_axis_tdata[19:12];
    end
  end

  // single pass: tick timing, register read, register write
  always_comb begin
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [ACC_W-1:0]  limit;
    logic [ACC_W-1:0]  acc_sub;
    logic              fire;
    logic [BYTE_W-1:0] line_inc;
    logic              hit_inc;
    logic [BYTE_W-1:0] st_wr;

    vmode_next        = vmode;
    cycle_accum_next  = cycle_accum;
    line_counter_next = line_counter;
    lcd_control_next  = lcd_control;
    status_en_next    = status_en;
    coinc_next        = coinc;
    view_y_next       = view_y;
    view_x_next       = view_x;
    line_compare_next = line_compare;
    bg_palette_next   = bg_palette;
    obj_palette0_next = obj_palette0;
    obj_palette1_next = obj_palette1;
    window_y_next     = window_y;
    window_x_next     = window_x;
    rd_data  = '0;
    vbl_irq  = 1'b0;
    stat_irq = 1'b0;
    dma_req  = 1'b0;
    dma_byte = '0;

    // saturating accumulate
    sum     = {1'b0, cycle_accum} + {{(ACC_W+1-BYTE_W){1'b0}}, in_cyc};
    acc_sat = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];

    unique case (vmode)
      VM_HBLANK: limit = ACC_W'(hblank_cycles);
      VM_VBLANK: limit = ACC_W'(vblank_line_cycles);
      VM_OAM:    limit = ACC_W'(oam_search_cycles);
      VM_XFER:   limit = ACC_W'(transfer_cycles);
      default:   limit = ACC_W'(oam_search_cycles);
    endcase
    fire     = acc_sat >= limit;
    acc_sub  = acc_sat - limit;
    line_inc = line_counter + 8'd1;
    hit_inc  = line_inc == line_compare;
    st_wr    = (status_byte & ST_READONLY) | (in_wdata & ST_WRITABLE);

    case (in_kind)
      KIND_TICK: begin
        cycle_accum_next = acc_sat;
        unique case (vmode)
          VM_HBLANK: begin
            if (fire) begin
              cycle_accum_next  = acc_sub;
              line_counter_next = line_inc;
              coinc_next        = hit_inc;
              if (hit_inc && status_en[ST_LYC_BIT-3]) stat_irq = 1'b1;
              if (line_inc == VBL_LINE) begin
                vbl_irq = 1'b1;
                if (status_en[ST_VBL_BIT-3]) stat_irq = 1'b1;
                vmode_next = VM_VBLANK;
              end else begin
                if (status_en[ST_OAM_BIT-3]) stat_irq = 1'b1;
                vmode_next = VM_OAM;
              end
            end
          end
          VM_VBLANK: begin
            if (fire) begin
              cycle_accum_next  = acc_sub;
              line_counter_next = line_inc;
              coinc_next        = hit_inc;
              if (hit_inc && status_en[ST_LYC_BIT-3]) stat_irq = 1'b1;
            end
            // frame end, checked even on a tick that did not step the line
            if (line_counter_next > LAST_LINE_B) begin
              cycle_accum_next  = '0;
              line_counter_next = '0;
              coinc_next        = line_compare == '0;
              if (coinc_next && status_en[ST_LYC_BIT-3]) stat_irq = 1'b1;
              if (status_en[ST_OAM_BIT-3]) stat_irq = 1'b1;
              vmode_next = VM_OAM;
            end
          end
          VM_OAM: begin
            if (fire) begin
              cycle_accum_next = acc_sub;
              vmode_next       = VM_XFER;
            end
          end
          VM_XFER: begin
            if (fire) begin
              cycle_accum_next = acc_sub;
              if (status_en[ST_HBL_BIT-3]) stat_irq = 1'b1;
              vmode_next = VM_HBLANK;
            end
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        unique case (in_sel)
          REG_CONTROL: rd_data = lcd_control;
          REG_STATUS:  rd_data = status_byte;
          REG_SCROLLY: rd_data = view_y;
          REG_SCROLLX: rd_data = view_x;
          REG_LINE:    rd_data = line_counter;
          REG_COMPARE: rd_data = line_compare;
          REG_BGPAL:   rd_data = bg_palette;
          REG_OBPAL0:  rd_data = obj_palette0;
          REG_OBPAL1:  rd_data = obj_palette1;
          REG_WINY:    rd_data = window_y;
          REG_WINX:    rd_data = window_x;
          default:     rd_data = '0;
        endcase
      end
      KIND_WRITE: begin
        unique case (in_sel)
          REG_CONTROL: lcd_control_next = in_wdata;
          REG_STATUS:  status_en_next   = st_wr[7:3];
          REG_SCROLLY: view_y_next      = in_wdata;
          REG_SCROLLX: view_x_next      = in_wdata;
          REG_LINE:    line_counter_next = '0;
          REG_COMPARE: line_compare_next = in_wdata;
          REG_DMA: begin
            dma_req  = 1'b1;
            dma_byte = in_wdata;
          end
          REG_BGPAL:   bg_palette_next   = in_wdata;
          REG_OBPAL0:  obj_palette0_next = in_wdata;
          REG_OBPAL1:  obj_palette1_next = in_wdata;
          REG_WINY:    window_y_next     = in_wdata;
          REG_WINX:    window_x_next     = in_wdata;
          default:     ;
        endcase
      end
      default: ;
    endcase
  end

  // state commits only when the beat moves on to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vmode        <= VM_OAM;
      cycle_accum  <= '0;
      line_counter <= '0;
      lcd_control  <= '0;
      status_en    <= '0;
      coinc        <= 1'b0;
      view_y       <= '0;
      view_x       <= '0;
      line_compare <= '0;
      bg_palette   <= '0;
      obj_palette0 <= '0;
      obj_palette1 <= '0;
      window_y     <= '0;
      window_x     <= '0;
    end else if (advance) begin
      vmode        <= vmode_next;
      cycle_accum  <= cycle_accum_next;
      line_counter <= line_counter_next;
      lcd_control  <= lcd_control_next;
      status_en    <= status_en_next;
      coinc        <= coinc_next;
      view_y       <= view_y_next;
      view_x       <= view_x_next;
      line_compare <= line_compare_next;
      bg_palette   <= bg_palette_next;
      obj_palette0 <= obj_palette0_next;
      obj_palette1 <= obj_palette1_next;
      window_y     <= window_y_next;
      window_x     <= window_x_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_read_data  <= rd_data;
      o_vblank_irq <= vbl_irq;
      o_lcd_irq    <= stat_irq;
      o_dma_start  <= dma_req;
      o_dma_page   <= dma_byte;
      o_mode       <= vmode_code(vmode_next);
    end
  end

  assign m_axis_tdata = {3'b000, o_mode, o_dma_page, o_dma_start, o_lcd_irq,
                         o_vblank_irq, o_read_data};

  // a vblank request always leaves the timer in vblank
  `ASSERT_IMP(a_vbl_mode, clk, rst, m_axis_tvalid && o_vblank_irq, o_mode == MODE_VBLANK)
  // no page byte without a dma request
  `ASSERT_IMP(a_dma_page, clk, rst, m_axis_tvalid && !o_dma_start, o_dma_page == '0)
  // a held beat with an empty output stage always moves on
  `ASSERT_NEXT(a_advance, clk, rst, in_valid && !m_axis_tvalid, m_axis_tvalid)

endmodule
